@@ design/clebuf_pkg.sv @@
// Shared types and key codes for the cursor line edit buffer.
`default_nettype none

package clebuf_pkg;

	localparam logic [1:0] OP_KEY   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [7:0] KEY_ESC     = 8'h1B;
	localparam logic [7:0] KEY_DEL     = 8'h7F;
	localparam logic [7:0] KEY_BS      = 8'h08;
	localparam logic [7:0] KEY_CR      = 8'h0D;
	localparam logic [7:0] KEY_LF      = 8'h0A;
	localparam logic [7:0] KEY_BRACKET = 8'h5B;
	localparam logic [7:0] KEY_RIGHT   = 8'h43;
	localparam logic [7:0] KEY_LEFT    = 8'h44;
	localparam logic [7:0] PRINT_LOW   = 8'd32;
	localparam logic [7:0] PRINT_END   = 8'd127;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] key_byte;
		logic [8:0] read_index;
	} request_t;

	typedef struct packed {
		logic [8:0] cursor_position;
		logic [8:0] char_count;
		logic [7:0] read_char;
		logic       changed;
		logic       dropped_full;
	} result_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_CLEAR,
		ACT_READ,
		ACT_RIGHT,
		ACT_LEFT,
		ACT_DELETE,
		ACT_INSERT
	} action_t;

	// decoded request from the key parser to the edit sequencer
	typedef struct packed {
		action_t    act;
		logic [7:0] ch;
	} key_act_t;

	// per-request flags from the edit sequencer
	typedef struct packed {
		logic [7:0] rd_char;
		logic       changed;
		logic       full;
	} fin_t;

endpackage

`default_nettype wire

@@ design/clebuf_ram.sv @@
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none

module clebuf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ design/clebuf_key.sv @@
// Key byte parser: escape sequence tracking and decode into edit actions.
`default_nettype none

module clebuf_key
	import clebuf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     go,
	input  wire request_t request,
	output key_act_t      act
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ESC,
		PH_CSI
	} phase_t;

	phase_t     phase_q;
	phase_t     phase_d;
	logic [7:0] k;

	assign k = request.key_byte;

	always_comb begin
		act.act = ACT_NONE;
		act.ch  = k;
		phase_d = PH_IDLE;
		case (request.operation)
			OP_KEY: begin
				case (phase_q)
					PH_ESC: begin
						phase_d = (k == KEY_BRACKET) ? PH_CSI : PH_IDLE;
					end
					PH_CSI: begin
						if (k == KEY_RIGHT) begin
							act.act = ACT_RIGHT;
						end else if (k == KEY_LEFT) begin
							act.act = ACT_LEFT;
						end
					end
					default: begin
						if (k == KEY_ESC) begin
							phase_d = PH_ESC;
						end else if (k == KEY_DEL || k == KEY_BS) begin
							act.act = ACT_DELETE;
						end else if (k == KEY_CR || k == KEY_LF) begin
							act.act = ACT_INSERT;
							act.ch  = KEY_LF;
						end else if (k >= PRINT_LOW && k < PRINT_END) begin
							act.act = ACT_INSERT;
						end
					end
				endcase
			end
			OP_CLEAR: act.act = ACT_CLEAR;
			OP_READ:  act.act = ACT_READ;
			default:  act.act = ACT_NONE;
		endcase
	end

	// escape phase only moves on key requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (go && request.operation == OP_KEY) begin
			phase_q <= phase_d;
		end
	end

endmodule

`default_nettype wire

@@ design/clebuf_ctrl.sv @@
// Edit sequencer: cursor, length and read-modify-write shifting of the text RAM.
`default_nettype none

module clebuf_ctrl
	import clebuf_pkg::*;
#(
	parameter int BUFFER_DEPTH = 512
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            go,
	input  wire key_act_t                        act,
	input  wire logic [8:0]                      read_index,
	output logic                                 busy,
	output logic                                 done,
	output fin_t                                 fin,
	output logic [$clog2(BUFFER_DEPTH)-1:0]      cur_out,
	output logic [$clog2(BUFFER_DEPTH)-1:0]      len_out
);

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam logic [AW-1:0] FULL_LEN = AW'(BUFFER_DEPTH - 2);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_WR,
		ST_PUT,
		ST_RDW
	} state_t;

	state_t        state_q, state_d;
	logic [AW-1:0] len_q, len_d;
	logic [AW-1:0] cur_q, cur_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [7:0]    ch_q, ch_d;
	logic          del_q, del_d;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rdata;

	logic [AW+8:0] idx_w, len_w;
	logic [AW-1:0] idx_a;
	logic          idx_in;

	assign idx_w  = {{AW{1'b0}}, read_index};
	assign len_w  = {9'b0, len_q};
	assign idx_a  = idx_w[AW-1:0];
	assign idx_in = idx_w < len_w;

	clebuf_ram #(
		.WIDTH (8),
		.DEPTH (BUFFER_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		state_d = state_q;
		len_d   = len_q;
		cur_d   = cur_q;
		ptr_d   = ptr_q;
		ch_d    = ch_q;
		del_d   = del_q;
		done    = 1'b0;
		fin     = '0;
		we      = 1'b0;
		waddr   = ptr_q;
		wdata   = rdata;
		raddr   = ptr_q;
		case (state_q)
			ST_IDLE: begin
				raddr = idx_a;
				if (go) begin
					case (act.act)
						ACT_CLEAR: begin
							len_d       = '0;
							cur_d       = '0;
							done        = 1'b1;
							fin.changed = 1'b1;
						end
						ACT_RIGHT: begin
							done = 1'b1;
							if (cur_q < len_q) begin
								cur_d       = cur_q + AW'(1);
								fin.changed = 1'b1;
							end
						end
						ACT_LEFT: begin
							done = 1'b1;
							if (cur_q != '0) begin
								cur_d       = cur_q - AW'(1);
								fin.changed = 1'b1;
							end
						end
						ACT_INSERT: begin
							if (len_q >= FULL_LEN) begin
								done     = 1'b1;
								fin.full = 1'b1;
							end else begin
								ch_d  = act.ch;
								del_d = 1'b0;
								if (cur_q == len_q) begin
									state_d = ST_PUT;
								end else begin
									ptr_d   = len_q - AW'(1);
									state_d = ST_RD;
								end
							end
						end
						ACT_DELETE: begin
							if (cur_q == '0) begin
								done = 1'b1;
							end else begin
								cur_d = cur_q - AW'(1);
								if (cur_q == len_q) begin
									len_d       = len_q - AW'(1);
									done        = 1'b1;
									fin.changed = 1'b1;
								end else begin
									// move [cur, len) down by one
									ptr_d   = cur_q;
									del_d   = 1'b1;
									state_d = ST_RD;
								end
							end
						end
						ACT_READ: begin
							if (idx_in) begin
								state_d = ST_RDW;
							end else begin
								done = 1'b1;
							end
						end
						default: done = 1'b1;
					endcase
				end
			end
			ST_RD: state_d = ST_WR;
			ST_WR: begin
				we = 1'b1;
				if (!del_q) begin
					waddr = ptr_q + AW'(1);
					if (ptr_q == cur_q) begin
						state_d = ST_PUT;
					end else begin
						ptr_d   = ptr_q - AW'(1);
						state_d = ST_RD;
					end
				end else begin
					waddr = ptr_q - AW'(1);
					if (ptr_q == len_q - AW'(1)) begin
						len_d       = len_q - AW'(1);
						done        = 1'b1;
						fin.changed = 1'b1;
						state_d     = ST_IDLE;
					end else begin
						ptr_d   = ptr_q + AW'(1);
						state_d = ST_RD;
					end
				end
			end
			ST_PUT: begin
				we          = 1'b1;
				waddr       = cur_q;
				wdata       = ch_q;
				cur_d       = cur_q + AW'(1);
				len_d       = len_q + AW'(1);
				done        = 1'b1;
				fin.changed = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_RDW: begin
				done        = 1'b1;
				fin.rd_char = rdata;
				state_d     = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy    = state_q != ST_IDLE;
	assign cur_out = cur_d;
	assign len_out = len_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= '0;
			cur_q   <= '0;
			ptr_q   <= '0;
			ch_q    <= '0;
			del_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			cur_q   <= cur_d;
			ptr_q   <= ptr_d;
			ch_q    <= ch_d;
			del_q   <= del_d;
		end
	end

	a_cur_in_text: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= len_q)
		else $error("cursor beyond text length");

	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= FULL_LEN)
		else $error("text length above capacity");

	a_ptr_in_text: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |-> (ptr_q < len_q))
		else $error("shift pointer outside text");

	a_shift_len_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |=> $stable(len_q))
		else $error("length moved during shift read");

	a_put_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUT) |=> (len_q == $past(len_q) + AW'(1)))
		else $error("insert did not grow text");

endmodule

`default_nettype wire

@@ design/cursor_line_edit_buffer.sv @@
// Top level of the cursor line edit buffer: parser, sequencer, result register.
//
// Usage: drive request (operation, key_byte, read_index) and raise start;
// the request is taken at a rising edge with start high and busy low.
// Exactly one result per request appears on result for one cycle, marked
// by done; the receiver cannot stall, so it must capture it then.
// Handling from the accepting edge to done:
//   clear, cursor moves, escape bytes, ignored bytes, full inserts,
//   backspace at the start, delete at the end of the text, reads beyond
//   the text: busy never rises. read inside the text: one RAM read.
//   insert: the text from the cursor on moves up by one, then the key is put;
//   delete: the text from the old cursor on moves down by one. Each shifted
//   character costs one RAM read and one RAM write on the single text RAM.
// busy falls on the edge that loads the result, so the next request may be
// taken while done is high.
// Reset clears length, cursor and escape state; the text RAM is not
// cleared, nothing below the length is ever read before being written.
`default_nettype none

module cursor_line_edit_buffer
	import clebuf_pkg::*;
#(
	parameter int BUFFER_DEPTH = 512
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire request_t request,
	output result_t       result,
	output logic          done
);

	localparam int AW = $clog2(BUFFER_DEPTH);

	logic          go;
	key_act_t      act;
	logic          fin_done;
	fin_t          fin;
	logic [AW-1:0] cur_n, len_n;
	logic [AW+8:0] cur_w, len_w;

	assign go = start && !busy;

	clebuf_key u_key (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.request (request),
		.act     (act)
	);

	clebuf_ctrl #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.act        (act),
		.read_index (request.read_index),
		.busy       (busy),
		.done       (fin_done),
		.fin        (fin),
		.cur_out    (cur_n),
		.len_out    (len_n)
	);

	// positions are reported in 9 bits whatever the depth
	assign cur_w = {9'b0, cur_n};
	assign len_w = {9'b0, len_n};

	// result register: one-cycle strobe, payload held until the next result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= fin_done;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_done) begin
			result.cursor_position <= cur_w[8:0];
			result.char_count      <= len_w[8:0];
			result.read_char       <= fin.rd_char;
			result.changed         <= fin.changed;
			result.dropped_full    <= fin.full;
		end
	end

endmodule

`default_nettype wire
